@@ hdl/srs_pkg.sv @@
// Shared types and constants for the shaping run segmenter.
package srs_pkg;

	// Token opcodes carried on the input side band.
	typedef enum logic {
		OP_LEVEL = 1'b0,
		OP_CLOSE = 1'b1
	} opcode_t;

	// Result kinds carried on the output side band.
	typedef enum logic [1:0] {
		KIND_BOUNDARY = 2'd0,
		KIND_SENTINEL = 2'd1,
		KIND_ERROR    = 2'd2
	} kind_t;

	// Error codes reported with an error result.
	typedef enum logic [1:0] {
		ERR_MIXED_PARITY = 2'd0,
		ERR_LEVEL_RANGE  = 2'd1,
		ERR_FACE_SOURCE  = 2'd2
	} err_code_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_PARAGRAPH_LEVEL = 2'd0,
		CFG_INVALID_FACE    = 2'd1,
		CFG_UNKNOWN_SCRIPT  = 2'd2,
		CFG_MISSING_SOURCE  = 2'd3
	} cfg_index_t;

	localparam logic [6:0] MAX_LEVEL          = 7'd126;
	localparam logic [2:0] MISSING_SOURCE_RST = 3'd3;

	// Result queue depth and pointer widths.
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCOUNT_W = $clog2(QDEPTH + 1);

	// One result item as held in the result queue.
	typedef struct packed {
		kind_t       kind;
		logic [31:0] cluster_pos;
		logic [31:0] face;
		logic [15:0] script;
		logic        right_to_left;
		logic [2:0]  source;
		logic [6:0]  level;
		err_code_t   error_code;
		logic        last;
	} result_t;

endpackage

@@ hdl/shaping_run_segmenter.sv @@
// Top level of the shaping run segmenter: token register, run logic and result queue.
//
// Usage: level tokens (tuser = 0) carry the active bidi levels of the cluster being
// built; close tokens (tuser = 1) carry script, face and fallback source, and tlast
// on a close token ends the paragraph. Each close token whose key differs from the
// previous run gives a run boundary (tuser = 0); the paragraph end adds a closing
// sentinel (tuser = 1). Errors (tuser = 2) are reported once and the rest of the
// paragraph is dropped. tlast on the output marks the last result of one token.
// Throughput: one token per cycle while the four-entry result queue has two entries
// free, which sets the token rate; a token that gives two results writes both into
// the queue together. A token passes through the token register and then the
// result queue before its first result appears.
// When the receiver stalls, the queue fills and s_axis_tready drops; nothing is lost.
// Reset clears the paragraph state, the queue and the configuration registers
// (missing source code resets to 3). Configuration is written through cfg_we,
// cfg_index and cfg_data while the block is idle; writing the paragraph level also
// loads the inherited level while no cluster of the paragraph has closed.
module shaping_run_segmenter
	import srs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// Token input.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata, low bit up: level[6:0], script[22:7], face_id[54:23],
	// fb_source[57:55], zero fill[63:58].
	input  logic [63:0] s_axis_tdata,
	// tuser: opcode.
	input  logic        s_axis_tuser,
	// tlast: end_of_paragraph.
	input  logic        s_axis_tlast,
	// Result output.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata, low bit up: cluster_pos[31:0], out_face[63:32], out_script[79:64],
	// right_to_left[80], out_source[83:81], run_level[90:84], error_code[92:91],
	// zero fill[95:93].
	output logic [95:0] m_axis_tdata,
	// tuser: kind.
	output logic [1:0]  m_axis_tuser,
	// tlast: last.
	output logic        m_axis_tlast
);

	// Configuration registers.
	logic        para_level_q;
	logic [31:0] inv_face_q;
	logic [15:0] unk_script_q;
	logic [2:0]  miss_src_q;

	// Token register.
	logic        valid_s1;
	opcode_t     op_s1;
	logic [6:0]  level_s1;
	logic [15:0] script_s1;
	logic [31:0] face_s1;
	logic [2:0]  source_s1;
	logic        eop_s1;

	// Paragraph state.
	logic [31:0] clusters_q;
	logic [6:0]  inherited_q;
	logic [6:0]  pending_level_q;
	logic        pending_has_q;
	logic [31:0] prior_face_q;
	logic [15:0] prior_script_q;
	logic [2:0]  prior_source_q;
	logic [6:0]  prior_level_q;
	logic        have_prior_q;
	logic        aborted_q;

	// Result queue.
	result_t              queue_q [QDEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QCOUNT_W-1:0]  count_q;

	// Per-token decisions.
	logic        proc;
	logic        pop;
	logic [1:0]  push_n;
	result_t     item0;
	result_t     item1;
	logic        mismatch;
	logic        boundary;
	logic        err_level;
	logic        err_parity;
	logic [6:0]  clevel;
	logic [31:0] clusters_inc;
	logic        new_para;

	// The token is processed once two queue entries are free.
	assign proc          = valid_s1 && (count_q <= QCOUNT_W'(QDEPTH - 2));
	assign s_axis_tready = !valid_s1 || proc;
	assign pop           = m_axis_tvalid && m_axis_tready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			para_level_q <= 1'b0;
			inv_face_q   <= '0;
			unk_script_q <= '0;
			miss_src_q   <= MISSING_SOURCE_RST;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_PARAGRAPH_LEVEL: para_level_q <= cfg_data[0];
				CFG_INVALID_FACE:    inv_face_q   <= cfg_data;
				CFG_UNKNOWN_SCRIPT:  unk_script_q <= cfg_data[15:0];
				CFG_MISSING_SOURCE:  miss_src_q   <= cfg_data[2:0];
				default:             para_level_q <= para_level_q;
			endcase
		end
	end

	// Token register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Token register payload.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1     <= opcode_t'(s_axis_tuser);
			level_s1  <= s_axis_tdata[6:0];
			script_s1 <= s_axis_tdata[22:7];
			face_s1   <= s_axis_tdata[54:23];
			source_s1 <= s_axis_tdata[57:55];
			eop_s1    <= s_axis_tlast;
		end
	end

	// Checks and the cluster level of a close token.
	assign err_level    = (level_s1 > MAX_LEVEL);
	assign err_parity   = pending_has_q && (pending_level_q[0] != level_s1[0]);
	assign mismatch     = (source_s1 > miss_src_q) ||
		((source_s1 == miss_src_q) != (face_s1 == inv_face_q));
	assign clevel       = pending_has_q ? pending_level_q : inherited_q;
	assign clusters_inc = clusters_q + 32'd1;
	assign boundary     = !have_prior_q || (face_s1 != prior_face_q) ||
		(script_s1 != prior_script_q) || (source_s1 != prior_source_q) ||
		(clevel != prior_level_q);
	assign new_para     = (op_s1 == OP_CLOSE) && eop_s1;

	// Build up to two results for the token in the register.
	always_comb begin
		result_t err_item;
		result_t bnd_item;
		result_t snt_item;

		err_item = '0;
		err_item.kind          = KIND_ERROR;
		err_item.cluster_pos   = clusters_q;
		err_item.last          = 1'b1;

		bnd_item = '0;
		bnd_item.kind          = KIND_BOUNDARY;
		bnd_item.cluster_pos   = clusters_q;
		bnd_item.face          = face_s1;
		bnd_item.script        = script_s1;
		bnd_item.right_to_left = clevel[0];
		bnd_item.source        = source_s1;
		bnd_item.level         = clevel;
		bnd_item.error_code    = ERR_MIXED_PARITY;
		bnd_item.last          = !eop_s1;

		// The sentinel level equals the level of the last run, which is this cluster's.
		snt_item = '0;
		snt_item.kind          = KIND_SENTINEL;
		snt_item.cluster_pos   = clusters_inc;
		snt_item.face          = inv_face_q;
		snt_item.script        = unk_script_q;
		snt_item.right_to_left = clevel[0];
		snt_item.source        = miss_src_q;
		snt_item.level         = clevel;
		snt_item.error_code    = ERR_MIXED_PARITY;
		snt_item.last          = 1'b1;

		push_n = 2'd0;
		item0  = err_item;
		item1  = snt_item;
		if (aborted_q) begin
			push_n = 2'd0;
		end else if (op_s1 == OP_LEVEL) begin
			if (err_level) begin
				push_n = 2'd1;
				item0.error_code = ERR_LEVEL_RANGE;
			end else if (err_parity) begin
				push_n = 2'd1;
				item0.error_code = ERR_MIXED_PARITY;
			end
		end else if (mismatch) begin
			push_n = 2'd1;
			item0.error_code = ERR_FACE_SOURCE;
		end else if (boundary) begin
			item0  = bnd_item;
			push_n = eop_s1 ? 2'd2 : 2'd1;
		end else if (eop_s1) begin
			item0  = snt_item;
			push_n = 2'd1;
		end
	end

	// Paragraph state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clusters_q      <= '0;
			inherited_q     <= '0;
			pending_level_q <= '0;
			pending_has_q   <= 1'b0;
			prior_face_q    <= '0;
			prior_script_q  <= '0;
			prior_source_q  <= '0;
			prior_level_q   <= '0;
			have_prior_q    <= 1'b0;
			aborted_q       <= 1'b0;
		end else if (proc) begin
			if (new_para) begin
				clusters_q      <= '0;
				inherited_q     <= {6'd0, para_level_q};
				pending_level_q <= '0;
				pending_has_q   <= 1'b0;
				prior_face_q    <= '0;
				prior_script_q  <= '0;
				prior_source_q  <= '0;
				prior_level_q   <= '0;
				have_prior_q    <= 1'b0;
				aborted_q       <= 1'b0;
			end else if (!aborted_q) begin
				if (op_s1 == OP_LEVEL) begin
					if (err_level || err_parity) begin
						aborted_q <= 1'b1;
					end else if (!pending_has_q) begin
						pending_level_q <= level_s1;
						pending_has_q   <= 1'b1;
					end
				end else if (mismatch) begin
					aborted_q <= 1'b1;
				end else begin
					inherited_q     <= clevel;
					pending_level_q <= '0;
					pending_has_q   <= 1'b0;
					prior_face_q    <= face_s1;
					prior_script_q  <= script_s1;
					prior_source_q  <= source_s1;
					prior_level_q   <= clevel;
					have_prior_q    <= 1'b1;
					clusters_q      <= clusters_inc;
				end
			end
		end else if (cfg_we && (cfg_index_t'(cfg_index) == CFG_PARAGRAPH_LEVEL) &&
				(clusters_q == '0)) begin
			inherited_q <= {6'd0, cfg_data[0]};
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (proc) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + (proc ? QCOUNT_W'(push_n) : '0) - (pop ? QCOUNT_W'(1) : '0);
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (proc && (push_n != 2'd0)) begin
			queue_q[wr_ptr_q] <= item0;
		end
		if (proc && (push_n == 2'd2)) begin
			queue_q[wr_ptr_q + QPTR_W'(1)] <= item1;
		end
	end

	// Output side from the queue head.
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tuser  = queue_q[rd_ptr_q].kind;
	assign m_axis_tlast  = queue_q[rd_ptr_q].last;
	assign m_axis_tdata  = {3'd0, queue_q[rd_ptr_q].error_code, queue_q[rd_ptr_q].level,
		queue_q[rd_ptr_q].source, queue_q[rd_ptr_q].right_to_left,
		queue_q[rd_ptr_q].script, queue_q[rd_ptr_q].face,
		queue_q[rd_ptr_q].cluster_pos};

	// The queue never holds more than its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCOUNT_W'(QDEPTH))
		else $error("result queue overfilled");

	// Once aborted, tokens of the paragraph give no result.
	assert property (@(posedge clk) disable iff (!arst_n)
		proc && aborted_q |-> push_n == 2'd0)
		else $error("result produced after an error");

	// An error that does not end the paragraph leaves the block aborted.
	assert property (@(posedge clk) disable iff (!arst_n)
		proc && (push_n != 2'd0) && (item0.kind == KIND_ERROR) && !new_para |=> aborted_q)
		else $error("error did not abort the paragraph");

	// Two results come only from a close token that ends the paragraph.
	assert property (@(posedge clk) disable iff (!arst_n)
		proc && (push_n == 2'd2) |-> new_para && (item1.kind == KIND_SENTINEL))
		else $error("second result without paragraph end");

endmodule
